// File: rtl/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg
// Shared widths, stream layout and result type for the SOS Kawasaki step unit.
// ----------------------------------------------------------------------------
package skm_pkg;

  localparam int unsigned SITE_W    = 8;
  localparam int unsigned RND_W     = 32;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned THR_NUM   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DE_W      = 4;
  localparam int unsigned ENERGY_W  = 14;

  // slave tdata: site, direction, random_draw (41 bits, padded to 48)
  localparam int unsigned S_TDATA_W = 48;
  // master tdata: accepted, energy_change, total_energy (19 bits, padded to 24)
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_PAD_W   = M_TDATA_W - (1 + DE_W + ENERGY_W);

  typedef struct packed {
    logic                       accepted;
    logic signed [DE_W-1:0]     energy_change;
    logic        [ENERGY_W-1:0] total_energy;
  } result_t;

endpackage

// File: rtl/skm_height_ram.sv
// ----------------------------------------------------------------------------
// skm_height_ram
// Column height store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module skm_height_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: rtl/skm_out_buf.sv
// ----------------------------------------------------------------------------
// skm_out_buf
// Two-entry result buffer between the decision stage and the master stream.
// ----------------------------------------------------------------------------
module skm_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  skm_pkg::result_t data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output skm_pkg::result_t data_o,
  output logic [1:0]       count_o
);

  skm_pkg::result_t entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// File: rtl/sos_kawasaki_metropolis_step_unit.sv
// ----------------------------------------------------------------------------
// sos_kawasaki_metropolis_step_unit
// Metropolis step with height-conserving moves on a 1-D solid-on-solid ring.
//
//   port group   dir   content (lowest bit first)
//   s_axis_*     in    site[7:0], direction[8], random_draw[40:9]
//   m_axis_*     out   accepted[0], energy_change[4:1], total_energy[18:5]
//   cfg_*        in    write of accept_threshold_1..4 (index 0..3)
//
// No new move is taken while stage 1 is busy: four height reads share the two
// read ports of the height RAM, the two writes follow the decision. A taken
// move passes stage 1, stage 2 and the result buffer before m_axis_tvalid.
// After reset a clearing pass zeroes the RAM with s_axis_tready low. Results
// queue in a two-entry buffer; at most two moves sit between input and output.
// ----------------------------------------------------------------------------
module sos_kawasaki_metropolis_step_unit #(
  parameter int unsigned SITES        = 256,
  parameter int unsigned HEIGHT_LIMIT = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // site, direction, random_draw
  input  logic [skm_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accepted, energy_change, total_energy
  output logic [skm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [skm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [skm_pkg::THR_W-1:0]           cfg_data_i
);

  localparam int unsigned AW     = $clog2(SITES);
  localparam int unsigned HW     = $clog2(HEIGHT_LIMIT) + 1;
  localparam int unsigned WW     = HW + 4;
  localparam int unsigned SITE_N = 2 ** skm_pkg::SITE_W;
  localparam logic signed [WW-1:0] LIM_P = WW'(HEIGHT_LIMIT);
  localparam logic signed [WW-1:0] LIM_N = -LIM_P;

  // ---------------------------------------------------------------- helpers
  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(SITES - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(SITES - 1) : a - AW'(1);
  endfunction

  function automatic logic signed [WW-1:0] abs_w(input logic signed [WW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [HW-1:0] fwd_sel(
    input logic        [AW-1:0] a,
    input logic signed [HW-1:0] d,
    input logic                 v,
    input logic        [AW-1:0] a0,
    input logic signed [HW-1:0] d0,
    input logic        [AW-1:0] a1,
    input logic signed [HW-1:0] d1
  );
    logic signed [HW-1:0] r;
    r = d;
    if (v && a == a0) begin
      r = d0;
    end else if (v && a == a1) begin
      r = d1;
    end
    return r;
  endfunction

  // site modulo ring size, worked out at elaboration
  logic [AW-1:0] site_tbl [SITE_N];
  for (genvar g = 0; g < SITE_N; g++) begin : g_site_mod
    localparam int unsigned SiteMod = g % SITES;
    assign site_tbl[g] = AW'(SiteMod);
  end

  // ---------------------------------------------------------------- input
  logic [skm_pkg::SITE_W-1:0] in_site;
  logic                       in_plus;
  logic [skm_pkg::RND_W-1:0]  in_rnd;
  logic [AW-1:0]              in_x;
  logic [AW-1:0]              in_ib;
  logic                       in_fire;

  assign in_site = s_axis_tdata[skm_pkg::SITE_W-1:0];
  assign in_plus = s_axis_tdata[skm_pkg::SITE_W];
  assign in_rnd  = s_axis_tdata[skm_pkg::SITE_W+skm_pkg::RND_W:skm_pkg::SITE_W+1];
  assign in_x    = site_tbl[in_site];
  assign in_ib   = in_plus ? ring_dec(in_x) : ring_inc(in_x);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- state
  logic [skm_pkg::THR_W-1:0]    thr_q [skm_pkg::THR_NUM];
  logic [skm_pkg::ENERGY_W-1:0] energy_q, energy_d;
  logic                         clr_q;
  logic [AW-1:0]                clr_idx_q;

  // stage 1: item taken, reading x and the column behind it
  logic                      s1_v_q;
  logic [AW-1:0]             s1_x_q;
  logic [AW-1:0]             s1_ib_q;
  logic                      s1_plus_q;
  logic [skm_pkg::RND_W-1:0] s1_rnd_q;
  // stage 2: reading the donor and the column beyond it
  logic                      s2_v_q;
  logic [AW-1:0]             s2_x_q;
  logic [AW-1:0]             s2_ixp_q;
  logic [AW-1:0]             s2_inp_q;
  logic [skm_pkg::RND_W-1:0] s2_rnd_q;
  logic signed [HW-1:0]      s2_hx_q;
  logic signed [HW-1:0]      s2_hn_q;

  // last decided move: forwarding record, second half is the pending donor write
  logic                 fwd_v_q;
  logic                 pend_v_q;
  logic [AW-1:0]        fwd_a0_q;
  logic signed [HW-1:0] fwd_d0_q;
  logic [AW-1:0]        fwd_a1_q;
  logic signed [HW-1:0] fwd_d1_q;

  // ---------------------------------------------------------------- RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic signed [HW-1:0] ram_wdata;
  logic [AW-1:0]        ram_ra, ram_rb;
  logic [HW-1:0]        ram_da, ram_db;
  logic [AW-1:0]        s1_ixp, s1_inp;

  assign s1_ixp = s1_plus_q ? ring_inc(s1_x_q) : ring_dec(s1_x_q);
  assign s1_inp = s1_plus_q ? ring_inc(s1_ixp) : ring_dec(s1_ixp);
  assign ram_ra = s1_v_q ? s1_ixp : in_x;
  assign ram_rb = s1_v_q ? s1_inp : in_ib;

  skm_height_ram #(
    .DEPTH (SITES),
    .AW    (AW),
    .DW    (HW)
  ) u_height_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_ra),
    .raddr_b_i (ram_rb),
    .rdata_a_o (ram_da),
    .rdata_b_o (ram_db)
  );

  logic signed [HW-1:0] hx_f, hn_f, hxp_f, hnp_f;

  assign hx_f  = fwd_sel(s1_x_q, ram_da, fwd_v_q, fwd_a0_q, fwd_d0_q, fwd_a1_q, fwd_d1_q);
  assign hn_f  = fwd_sel(s1_ib_q, ram_db, fwd_v_q, fwd_a0_q, fwd_d0_q, fwd_a1_q, fwd_d1_q);
  assign hxp_f = fwd_sel(s2_ixp_q, ram_da, fwd_v_q, fwd_a0_q, fwd_d0_q, fwd_a1_q, fwd_d1_q);
  assign hnp_f = fwd_sel(s2_inp_q, ram_db, fwd_v_q, fwd_a0_q, fwd_d0_q, fwd_a1_q, fwd_d1_q);

  // ---------------------------------------------------------------- decision
  logic signed [WW-1:0]         hx_w, hn_w, hxp_w, hnp_w, de_w;
  logic                         blocked;
  logic                         acc;
  logic signed [skm_pkg::DE_W-1:0] de_n, de_out;
  logic [skm_pkg::DE_W-1:0]     de_m1;
  logic [skm_pkg::THR_W-1:0]    thr_sel;
  logic signed [HW-1:0]         hx_new, hxp_new;
  skm_pkg::result_t             res;

  always_comb begin
    hx_w    = WW'(s2_hx_q);
    hn_w    = WW'(s2_hn_q);
    hxp_w   = WW'(hxp_f);
    hnp_w   = WW'(hnp_f);
    blocked = (hx_w + WW'(1) >= LIM_P) || (hxp_w - WW'(1) <= LIM_N);
    de_w    = abs_w(hx_w + WW'(1) - hn_w) + abs_w(hx_w - hxp_w + WW'(2))
            + abs_w(hxp_w - WW'(1) - hnp_w)
            - abs_w(hx_w - hn_w) - abs_w(hx_w - hxp_w) - abs_w(hxp_w - hnp_w);
    de_n    = de_w[skm_pkg::DE_W-1:0];
    de_m1   = de_n - skm_pkg::DE_W'(1);
    thr_sel = thr_q[de_m1[skm_pkg::CFG_IDX_W-1:0]];
    acc     = !blocked && ((de_w <= 0) || (s2_rnd_q < thr_sel));
    de_out  = blocked ? '0 : de_n;
    hx_new  = s2_hx_q + HW'(1);
    hxp_new = hxp_f - HW'(1);
    energy_d = energy_q;
    if (s2_v_q && acc) begin
      energy_d = energy_q + {{(skm_pkg::ENERGY_W-skm_pkg::DE_W){de_n[skm_pkg::DE_W-1]}}, de_n};
    end
    res.accepted      = acc;
    res.energy_change = de_out;
    res.total_energy  = energy_d;
  end

  // write port: clearing pass, then gaining column, then donor on the next edge
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fwd_a1_q;
    ram_wdata = fwd_d1_q;
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else if (s2_v_q && acc) begin
      ram_we    = 1'b1;
      ram_waddr = s2_x_q;
      ram_wdata = hx_new;
    end else if (pend_v_q) begin
      ram_we    = 1'b1;
    end
  end

  // ---------------------------------------------------------------- output
  logic             ob_valid;
  skm_pkg::result_t ob_data;
  logic [1:0]       ob_cnt;

  skm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_v_q),
    .data_i  (res),
    .pop_i   (ob_valid && m_axis_tready),
    .valid_o (ob_valid),
    .data_o  (ob_data),
    .count_o (ob_cnt)
  );

  assign m_axis_tvalid = ob_valid;
  assign m_axis_tdata  = {{skm_pkg::M_PAD_W{1'b0}}, ob_data.total_energy,
                          ob_data.energy_change, ob_data.accepted};
  assign s_axis_tready = !clr_q && !s1_v_q && (ob_cnt + {1'b0, s2_v_q} < 2'd2);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < skm_pkg::THR_NUM; i++) begin
        thr_q[i] <= '0;
      end
      energy_q  <= '0;
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      fwd_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q[cfg_idx_i] <= cfg_data_i;
      end
      energy_q <= energy_d;
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(SITES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      s1_v_q   <= in_fire;
      s2_v_q   <= s1_v_q;
      pend_v_q <= s2_v_q && acc;
      if (s2_v_q) begin
        fwd_v_q <= acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q    <= in_x;
      s1_ib_q   <= in_ib;
      s1_plus_q <= in_plus;
      s1_rnd_q  <= in_rnd;
    end
    if (s1_v_q) begin
      s2_x_q   <= s1_x_q;
      s2_ixp_q <= s1_ixp;
      s2_inp_q <= s1_inp;
      s2_rnd_q <= s1_rnd_q;
      s2_hx_q  <= hx_f;
      s2_hn_q  <= hn_f;
    end
    if (s2_v_q) begin
      fwd_a0_q <= s2_x_q;
      fwd_d0_q <= hx_new;
      fwd_a1_q <= s2_ixp_q;
      fwd_d1_q <= hxp_new;
    end
  end

  // ---------------------------------------------------------------- checks
  a_stages_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_v_q && s2_v_q))
    else $error("both read stages occupied");

  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ob_cnt} + {2'b0, s1_v_q} + {2'b0, s2_v_q}) <= 3'd2)
    else $error("more moves in flight than result slots");

  a_energy_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s2_v_q && acc) |=> $stable(energy_q))
    else $error("energy changed without an accepted move");

  a_no_take_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_height_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !clr_q) |-> (WW'(ram_wdata) < LIM_P && WW'(ram_wdata) > LIM_N))
    else $error("height written beyond the limit");

endmodule
